FILE: hdl/smfp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor mask frame parser package
// Shared types, sensor codes, scaling constants and the pending-field pick.
// ----------------------------------------------------------------------------
package smfp_pkg;

   // Field widths of events and result beats, and the number of sensor fields.
   localparam int CODE_W  = 4;
   localparam int RAW_W   = 16;
   localparam int VALUE_W = 25;
   localparam int FIELD_COUNT = 10;

   // Sensor codes that need a scaling step.
   localparam logic [CODE_W-1:0] SENSOR_TEMP = 4'd0;
   localparam logic [CODE_W-1:0] SENSOR_PRES = 4'd2;
   localparam logic [CODE_W-1:0] SENSOR_RAIN = 4'd7;

   // Sensors whose field is a big-endian byte pair: temp, pres, co2, rain, solar.
   localparam logic [FIELD_COUNT-1:0] PAIR_SENSORS = 10'h295;

   // Reciprocal constants: value = floor(raw * RECIP / 2^RECIP_SHIFT).
   // Each is the ceiling of the exact ratio, which keeps the floor exact for
   // every 16-bit raw value.
   localparam int RECIP_W     = 33;
   localparam int RECIP_SHIFT = 26;
   localparam int QUOT_W      = 23;
   localparam logic [RECIP_W-1:0] TEMP_RECIP = 33'd171798692;   // 2.56
   localparam logic [RECIP_W-1:0] PRES_RECIP = 33'd1717986919;  // 25.6
   localparam logic [RECIP_W-1:0] RAIN_RECIP = 33'd4800055451;  // 71.5264
   localparam logic signed [VALUE_W-1:0] TEMP_OFFSET = 25'sd10240;  // 40.0 in Q.8

   // Result queue sizing.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // One parsed byte: a completed field and/or a short-frame error.
   typedef struct packed {
      logic              fld_valid;
      logic [CODE_W-1:0] fld_code;
      logic [RAW_W-1:0]  fld_raw;
      logic              err_valid;
      logic [CODE_W-1:0] err_code;
   } smfp_event_type;

   // One result beat.
   typedef struct packed {
      logic [CODE_W-1:0]         sensor_code;
      logic signed [VALUE_W-1:0] scaled_value;
      logic                      frame_error;
      logic                      run_end;
   } smfp_result_type;

   // Code of the lowest set bit; zero when nothing is pending.
   function automatic logic [CODE_W-1:0] lowest_pending(input logic [FIELD_COUNT-1:0] pend);
      logic [CODE_W-1:0] code;
      code = '0;
      for (int k = FIELD_COUNT - 1; k >= 0; k--) begin
         if (pend[k]) begin
            code = CODE_W'(k);
         end
      end
      return code;
   endfunction

endpackage

FILE: hdl/smfp_channels.sv
// ----------------------------------------------------------------------------
// Sensor mask frame parser channels
// Valid/ready channel bundles for the byte input and the result output.
// ----------------------------------------------------------------------------
interface smfp_req_if;
   logic        valid;
   logic        ready;
   logic        first_byte;
   logic [15:0] presence_mask;
   logic [7:0]  data_byte;
   logic        last_byte;

   modport source (output valid, first_byte, presence_mask, data_byte, last_byte,
                   input ready);
   modport sink (input valid, first_byte, presence_mask, data_byte, last_byte,
                 output ready);
endinterface

interface smfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         sensor_code;
   logic signed [24:0] scaled_value;
   logic               frame_error;
   logic               run_end;

   modport source (output valid, sensor_code, scaled_value, frame_error, run_end,
                   input ready);
   modport sink (input valid, sensor_code, scaled_value, frame_error, run_end,
                 output ready);
endinterface

FILE: hdl/smfp_parse.sv
// ----------------------------------------------------------------------------
// Frame byte parser
// Tracks the frame state and turns each accepted byte into a registered event.
// ----------------------------------------------------------------------------
module smfp_parse import smfp_pkg::*; #(
   parameter int HEADER_SKIP = 3
) (
   input  logic           clock,
   input  logic           reset,
   smfp_req_if.sink       req_bus,
   input  logic           room_ok,
   output smfp_event_type evt_ff
);

   localparam logic [1:0] SKIP_COUNT = 2'(HEADER_SKIP);

   logic                   accept;
   logic [1:0]             pos_ff, pos_in, pos0, pos1;
   logic [FIELD_COUNT-1:0] pend_ff, pend_in, pend0, pend1;
   logic [7:0]             hold_ff, hold_in, hold0, hold1;
   logic                   have_ff, have_in, have0, have1;
   logic                   active_ff, active_in, active0;
   logic [CODE_W-1:0]      code0, code1;
   logic                   fld;
   logic [RAW_W-1:0]       raw;
   smfp_event_type         evt_in;

   assign req_bus.ready = room_ok;
   assign accept = req_bus.valid & room_ok;

   // A first byte restarts the frame before the byte itself is counted.
   always_comb begin
      pend0   = req_bus.first_byte ? req_bus.presence_mask[FIELD_COUNT-1:0] : pend_ff;
      pos0    = req_bus.first_byte ? 2'd0 : pos_ff;
      hold0   = req_bus.first_byte ? 8'd0 : hold_ff;
      have0   = req_bus.first_byte ? 1'b0 : have_ff;
      active0 = req_bus.first_byte | active_ff;
      code0   = lowest_pending(pend0);
   end

   // Header skip, then assembly of the lowest pending field.
   always_comb begin
      pos1  = pos0;
      pend1 = pend0;
      hold1 = hold0;
      have1 = have0;
      fld   = 1'b0;
      raw   = {8'd0, req_bus.data_byte};
      if (pos0 < SKIP_COUNT) begin
         pos1 = pos0 + 2'd1;
      end else if (pend0 != '0) begin
         if (PAIR_SENSORS[code0]) begin
            if (!have0) begin
               hold1 = req_bus.data_byte;
               have1 = 1'b1;
            end else begin
               fld          = 1'b1;
               raw          = {hold0, req_bus.data_byte};
               pend1[code0] = 1'b0;
               have1        = 1'b0;
               hold1        = 8'd0;
            end
         end else begin
            fld          = 1'b1;
            pend1[code0] = 1'b0;
         end
      end
      code1 = lowest_pending(pend1);
   end

   // Next state and the event for the result path.
   always_comb begin
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      hold_in   = hold_ff;
      have_in   = have_ff;
      active_in = active_ff;
      evt_in    = '0;
      if (accept && active0) begin
         evt_in.fld_valid = fld;
         evt_in.fld_code  = code0;
         evt_in.fld_raw   = raw;
         pos_in           = pos1;
         if (req_bus.last_byte) begin
            evt_in.err_valid = (pend1 != '0);
            evt_in.err_code  = code1;
            active_in        = 1'b0;
            pend_in          = '0;
            have_in          = 1'b0;
            hold_in          = 8'd0;
         end else begin
            active_in = 1'b1;
            pend_in   = pend1;
            have_in   = have1;
            hold_in   = hold1;
         end
      end
   end

   // State and event registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         pend_ff   <= '0;
         hold_ff   <= '0;
         have_ff   <= 1'b0;
         active_ff <= 1'b0;
         evt_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
         hold_ff   <= hold_in;
         have_ff   <= have_in;
         active_ff <= active_in;
         evt_ff    <= evt_in;
      end
   end

   // An error event only follows an accepted last byte.
   assert property (@(posedge clock) disable iff (reset)
      evt_ff.err_valid |-> $past(accept && req_bus.last_byte))
      else $error("error event without a last byte");

   // Pending fields and a held high byte exist only inside an open frame.
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) || have_ff |-> active_ff)
      else $error("field state outside a frame");

   // A half-assembled pair always belongs to a pair sensor.
   assert property (@(posedge clock) disable iff (reset)
      have_ff |-> PAIR_SENSORS[lowest_pending(pend_ff)])
      else $error("held byte for a single-byte sensor");

endmodule

FILE: hdl/smfp_convert.sv
// ----------------------------------------------------------------------------
// Value converter
// Scales a field to signed Q.8 and orders the results of one event.
// ----------------------------------------------------------------------------
module smfp_convert import smfp_pkg::*; (
   input  smfp_event_type  evt,
   output smfp_result_type res0,
   output smfp_result_type res1,
   output logic [1:0]      push_count
);

   logic [RECIP_W-1:0]              recip;
   logic [RAW_W+RECIP_W-1:0]        product;
   logic [QUOT_W-1:0]               quotient;
   logic signed [VALUE_W-1:0]       value;
   smfp_result_type                 fld_res, err_res;

   // Reciprocal multiply for the sensors with a fractional scale.
   always_comb begin
      case (evt.fld_code)
         SENSOR_TEMP: recip = TEMP_RECIP;
         SENSOR_PRES: recip = PRES_RECIP;
         SENSOR_RAIN: recip = RAIN_RECIP;
         default:     recip = '0;
      endcase
   end

   assign product  = (RAW_W+RECIP_W)'(evt.fld_raw) * (RAW_W+RECIP_W)'(recip);
   assign quotient = QUOT_W'(product >> RECIP_SHIFT);

   // Final Q.8 value: offset for temperature, quotient as is for pressure and rain, plain shift for raw sensors.
   always_comb begin
      case (evt.fld_code)
         SENSOR_TEMP: value = $signed({2'b00, quotient}) - TEMP_OFFSET;
         SENSOR_PRES: value = $signed({2'b00, quotient});
         SENSOR_RAIN: value = $signed({2'b00, quotient});
         default:     value = $signed({1'b0, evt.fld_raw, 8'd0});
      endcase
   end

   // The field result goes first; the error result closes the run.
   always_comb begin
      fld_res.sensor_code  = evt.fld_code;
      fld_res.scaled_value = value;
      fld_res.frame_error  = 1'b0;
      fld_res.run_end      = ~evt.err_valid;
      err_res.sensor_code  = evt.err_code;
      err_res.scaled_value = '0;
      err_res.frame_error  = 1'b1;
      err_res.run_end      = 1'b1;
      res0 = evt.fld_valid ? fld_res : err_res;
      res1 = err_res;
      push_count = 2'(evt.fld_valid) + 2'(evt.err_valid);
   end

endmodule

FILE: hdl/smfp_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results a cycle and sends one a beat.
// ----------------------------------------------------------------------------
module smfp_result_fifo import smfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  smfp_result_type       res0,
   input  smfp_result_type       res1,
   input  logic [1:0]            push_count,
   output logic [FIFO_CNT_W-1:0] count,
   smfp_rsp_if.source            rsp_bus
);

   smfp_result_type       entries_ff [FIFO_DEPTH];
   smfp_result_type       head;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   // Head of the queue drives the result channel.
   assign head                 = entries_ff[rd_ptr_ff];
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.sensor_code  = head.sensor_code;
   assign rsp_bus.scaled_value = head.scaled_value;
   assign rsp_bus.frame_error  = head.frame_error;
   assign rsp_bus.run_end      = head.run_end;
   assign pop                  = rsp_bus.valid & rsp_bus.ready;
   assign count                = count_ff;

   // Pointer and fill arithmetic.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
   end

   // Result storage; one or two entries written per cycle.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= res0;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= res1;
      end
   end

   // Queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The input credit check must keep every push inside the queue.
   assert property (@(posedge clock) disable iff (reset)
      (4'(count_ff) + 4'(push_count)) <= 4'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Fill count and pointers stay consistent.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == 3'(FIFO_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with fill count");

endmodule

FILE: hdl/sensor_mask_frame_parser.sv
// ----------------------------------------------------------------------------
// Sensor mask frame parser
// Parses presence-mask sensor frames a byte at a time into scaled readings.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock unless the input is held off,
// and answers each completed sensor field with a code and a signed Q.8 value
// passed through the event register and the result queue. A byte ending both
// a field and a short frame gives two result beats. The byte path holds a
// frame state register, an event register and a single 16 x 33 reciprocal
// multiplier feeding a four-entry result queue; the input is held off only
// when the queue and event register together could not take two more results.
module sensor_mask_frame_parser import smfp_pkg::*; #(
   parameter int HEADER_SKIP = 3
) (
   input  logic       clock,
   input  logic       reset,
   smfp_req_if.sink   req_bus,
   smfp_rsp_if.source rsp_bus
);

   smfp_event_type        evt;
   smfp_result_type       res0, res1;
   logic [1:0]            push_count;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic                  room_ok;

   // Credit check: queued results plus the event in flight leave room for two.
   assign room_ok = (4'(fifo_count) + 4'(evt.fld_valid) + 4'(evt.err_valid))
                    <= 4'(FIFO_DEPTH - 2);

   smfp_parse #(
      .HEADER_SKIP (HEADER_SKIP)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .room_ok (room_ok),
      .evt_ff  (evt)
   );

   smfp_convert u_convert (
      .evt        (evt),
      .res0       (res0),
      .res1       (res1),
      .push_count (push_count)
   );

   smfp_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .res0       (res0),
      .res1       (res1),
      .push_count (push_count),
      .count      (fifo_count),
      .rsp_bus    (rsp_bus)
   );

endmodule
